// ===== hw/rtl/nmea_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_pkg
// shared types, codes and small tables for the nmea sentence parser
// ----------------------------------------------------------------------------
package nmea_pkg;

   // word classes handed from the front to the back
   localparam logic [1:0] TOK_CHAR   = 2'd0;
   localparam logic [1:0] TOK_COMMA  = 2'd1;
   localparam logic [1:0] TOK_END    = 2'd2;
   localparam logic [1:0] TOK_DOLLAR = 2'd3;

   typedef struct packed {
      logic [1:0] tok_class;
      logic [7:0] text;
   } token_type;

   // sentence kinds
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_GGA  = 3'd1;
   localparam logic [2:0] KIND_GLL  = 3'd2;
   localparam logic [2:0] KIND_GSA  = 3'd3;
   localparam logic [2:0] KIND_GSV  = 3'd4;
   localparam logic [2:0] KIND_RMC  = 3'd5;
   localparam logic [2:0] KIND_VTG  = 3'd6;

   // talkers
   localparam logic [2:0] TALK_NONE = 3'd0;
   localparam logic [2:0] TALK_BD   = 3'd1;
   localparam logic [2:0] TALK_GA   = 3'd2;
   localparam logic [2:0] TALK_GI   = 3'd3;
   localparam logic [2:0] TALK_GL   = 3'd4;
   localparam logic [2:0] TALK_GP   = 3'd5;
   localparam logic [2:0] TALK_GQ   = 3'd6;

   // field roles
   localparam logic [2:0] ROLE_NONE   = 3'd0;
   localparam logic [2:0] ROLE_LAT    = 3'd1;
   localparam logic [2:0] ROLE_LATHEM = 3'd2;
   localparam logic [2:0] ROLE_LON    = 3'd3;
   localparam logic [2:0] ROLE_LONHEM = 3'd4;
   localparam logic [2:0] ROLE_TIME   = 3'd5;
   localparam logic [2:0] ROLE_STATUS = 3'd6;
   localparam logic [2:0] ROLE_DATE   = 3'd7;

   localparam int MIN_W = 30;
   localparam int NUM_W = 54;
   localparam int SCALE_W = 36;
   localparam logic [23:0] E7 = 24'd10000000;
   localparam logic [54:0] LAT_MAX = 55'd900000000;
   localparam logic [54:0] LON_MAX = 55'd1800000000;
   localparam logic [33:0] UNIX_MAX = 34'd4102444799;
   localparam logic [16:0] EPOCH_DAYS = 17'd10957;
   localparam logic [16:0] SEC_PER_DAY = 17'd86400;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic [3:0] digit_val(input logic [7:0] c);
      logic [7:0] d;
      d = c - "0";
      return is_digit(c) ? d[3:0] : 4'd0;
   endfunction

   function automatic logic [2:0] decode_talker(input logic [15:0] h);
      logic [2:0] t;
      t = TALK_NONE;
      if (h == "BD" || h == "GB") t = TALK_BD;
      else if (h == "GA") t = TALK_GA;
      else if (h == "GI") t = TALK_GI;
      else if (h == "GL") t = TALK_GL;
      else if (h == "GP") t = TALK_GP;
      else if (h == "GQ") t = TALK_GQ;
      return t;
   endfunction

   function automatic logic [2:0] decode_kind(input logic [23:0] h);
      logic [2:0] k;
      k = KIND_NONE;
      if (h == "GGA") k = KIND_GGA;
      else if (h == "GLL") k = KIND_GLL;
      else if (h == "GSA") k = KIND_GSA;
      else if (h == "GSV") k = KIND_GSV;
      else if (h == "RMC") k = KIND_RMC;
      else if (h == "VTG") k = KIND_VTG;
      return k;
   endfunction

   function automatic logic [2:0] field_role(input logic [2:0] kind, input logic [4:0] f);
      logic [2:0] r;
      r = ROLE_NONE;
      if (kind == KIND_GGA) begin
         if (f >= 5'd2 && f <= 5'd5) r = 3'(f - 5'd1);
      end else if (kind == KIND_RMC) begin
         if (f == 5'd1) r = ROLE_TIME;
         else if (f == 5'd2) r = ROLE_STATUS;
         else if (f >= 5'd3 && f <= 5'd6) r = 3'(f - 5'd2);
         else if (f == 5'd9) r = ROLE_DATE;
      end
      return r;
   endfunction

   // 60 * 10^d
   function automatic logic [SCALE_W-1:0] minute_scale(input logic [3:0] d);
      logic [SCALE_W-1:0] s;
      case (d)
         4'd0: s = 36'd60;
         4'd1: s = 36'd600;
         4'd2: s = 36'd6000;
         4'd3: s = 36'd60000;
         4'd4: s = 36'd600000;
         4'd5: s = 36'd6000000;
         4'd6: s = 36'd60000000;
         4'd7: s = 36'd600000000;
         4'd8: s = 36'd6000000000;
         4'd9: s = 36'd60000000000;
         default: s = 36'd60000000000;
      endcase
      return s;
   endfunction

   function automatic logic [16:0] time_weight(input logic [2:0] p);
      logic [16:0] w;
      case (p)
         3'd0: w = 17'd36000;
         3'd1: w = 17'd3600;
         3'd2: w = 17'd600;
         3'd3: w = 17'd60;
         3'd4: w = 17'd10;
         3'd5: w = 17'd1;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] v;
      case (m)
         4'd1: v = 9'd0;
         4'd2: v = 9'd31;
         4'd3: v = 9'd59;
         4'd4: v = 9'd90;
         4'd5: v = 9'd120;
         4'd6: v = 9'd151;
         4'd7: v = 9'd181;
         4'd8: v = 9'd212;
         4'd9: v = 9'd243;
         4'd10: v = 9'd273;
         4'd11: v = 9'd304;
         4'd12: v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nmea_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_front
// takes text bytes, classifies them and queues words for the back end
// ----------------------------------------------------------------------------
module nmea_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_text_byte,
   output logic                     tok_valid,
   output nmea_pkg::token_type      tok,
   input  wire logic                tok_pop
);
   import nmea_pkg::*;

   token_type  q_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   token_type  cls;
   logic       push;

   always_comb begin
      cls.text = req_text_byte;
      if (req_text_byte == "$") cls.tok_class = TOK_DOLLAR;
      else if (req_text_byte == "*" || req_text_byte == 8'h0d || req_text_byte == 8'h0a)
         cls.tok_class = TOK_END;
      else if (req_text_byte == ",") cls.tok_class = TOK_COMMA;
      else cls.tok_class = TOK_CHAR;
   end

   assign req_ready = (cnt_ff != 3'd4);
   assign push      = req_valid && req_ready;
   assign tok_valid = (cnt_ff != 3'd0);
   assign tok       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = tok_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, tok_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= cls;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/nmea_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_back
// field parser, angle divider, date to unix seconds and result register
// ----------------------------------------------------------------------------
module nmea_back #(
   parameter int MAX_SENTENCE_CHARS = 128,
   parameter int MAX_MINUTE_DIGITS  = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tok_valid,
   input  wire nmea_pkg::token_type  tok,
   output logic                      tok_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_talker,
   output logic [2:0]                rsp_sentence_kind,
   output logic                      rsp_location_valid,
   output logic signed [30:0]        rsp_latitude_e7,
   output logic signed [31:0]        rsp_longitude_e7,
   output logic                      rsp_time_valid,
   output logic [31:0]               rsp_unix_seconds,
   output logic [9:0]                rsp_fraction_ms
);
   import nmea_pkg::*;

   localparam int LW  = $clog2(MAX_SENTENCE_CHARS + 1);
   localparam int MDW = $clog2(MAX_MINUTE_DIGITS + 1);

   localparam logic [2:0] S_READY = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_DAYS  = 3'd4;
   localparam logic [2:0] S_SECS  = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic               phase_ff, phase_in;
   logic [4:0]         fidx_ff, fidx_in;
   logic [6:0]         cif_ff, cif_in;
   logic [7:0]         hdr_ff [5];
   logic [7:0]         hdr_in [5];
   logic [2:0]         hlen_ff, hlen_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [9:0]         deg_ff, deg_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [MDW-1:0]     mdig_ff, mdig_in, ddig_ff, ddig_in;
   logic               dseen_ff, dseen_in;
   logic [31:0]        lat_ff, lat_in, lon_ff, lon_in;
   logic               latpos_ff, latpos_in, lonpos_ff, lonpos_in;
   logic [19:0]        sod_ff, sod_in;
   logic [9:0]         frac_ff, frac_in;
   logic [1:0]         fdig_ff, fdig_in;
   logic [3:0]         date_ff [6];
   logic [3:0]         date_in [6];
   logic               stat_ff, stat_in;
   logic [2:0]         talker_ff, talker_in, kind_ff, kind_in;
   logic               pend_end_ff, pend_end_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [SCALE_W:0]   rem_ff, rem_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [33:0]        degs_ff, degs_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [16:0]        days_ff, days_in;
   logic [31:0]        unix_ff, unix_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         o_talker_ff, o_talker_in, o_kind_ff, o_kind_in;
   logic               o_loc_ff, o_loc_in, o_tv_ff, o_tv_in;
   logic [30:0]        o_lat_ff, o_lat_in;
   logic [31:0]        o_lon_ff, o_lon_in, o_unix_ff, o_unix_in;
   logic [9:0]         o_frac_ff, o_frac_in;

   logic [2:0]         role;
   logic [7:0]         c;
   logic               clear_all, clear_field;
   logic [SCALE_W:0]   trial;
   logic [54:0]        vsum, vlim;
   logic [6:0]         day, month, yy;
   logic [3:0]         mon_c;
   logic [33:0]        secs;
   logic [31:0]        lat_neg, lon_neg;
   logic               loc, rmc;
   logic [1:0]         ndeg;

   assign role = field_role(kind_ff, fidx_ff);
   assign c    = tok.text;

   always_comb begin
      state_in = state_ff;   phase_in = phase_ff;   fidx_in = fidx_ff;
      cif_in = cif_ff;       hdr_in = hdr_ff;       hlen_in = hlen_ff;
      len_in = len_ff;       deg_in = deg_ff;       min_in = min_ff;
      mdig_in = mdig_ff;     ddig_in = ddig_ff;     dseen_in = dseen_ff;
      lat_in = lat_ff;       lon_in = lon_ff;       latpos_in = latpos_ff;
      lonpos_in = lonpos_ff; sod_in = sod_ff;       frac_in = frac_ff;
      fdig_in = fdig_ff;     date_in = date_ff;     stat_in = stat_ff;
      talker_in = talker_ff; kind_in = kind_ff;     pend_end_in = pend_end_ff;
      num_in = num_ff;       rem_in = rem_ff;       scale_in = scale_ff;
      degs_in = degs_ff;     cnt_in = cnt_ff;       days_in = days_ff;
      unix_in = unix_ff;
      o_talker_in = o_talker_ff; o_kind_in = o_kind_ff; o_loc_in = o_loc_ff;
      o_tv_in = o_tv_ff;     o_lat_in = o_lat_ff;   o_lon_in = o_lon_ff;
      o_unix_in = o_unix_ff; o_frac_in = o_frac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      clear_all = 1'b0;
      clear_field = 1'b0;
      tok_pop = 1'b0;
      trial = '0;
      vsum = '0;
      vlim = '0;
      day = '0; month = '0; yy = '0; mon_c = '0;
      secs = '0;
      lat_neg = 32'd0 - lat_ff;
      lon_neg = 32'd0 - lon_ff;
      loc = (kind_ff == KIND_GGA) || (kind_ff == KIND_RMC);
      rmc = (kind_ff == KIND_RMC);
      ndeg = (role == ROLE_LAT) ? 2'd2 : 2'd3;

      case (state_ff)
         S_READY: begin
            if (tok_valid) begin
               tok_pop = 1'b1;
               if (tok.tok_class == TOK_DOLLAR) begin
                  clear_all = 1'b1;
               end else if (phase_ff) begin
                  if (tok.tok_class != TOK_END && len_ff >= LW'(MAX_SENTENCE_CHARS)) begin
                     clear_all = 1'b1;
                  end else if (tok.tok_class == TOK_CHAR) begin
                     len_in = len_ff + LW'(1);
                     if (fidx_ff == 5'd0) begin
                        if (hlen_ff < 3'd5) begin
                           hdr_in[hlen_ff] = c;
                           hlen_in = hlen_ff + 3'd1;
                        end
                     end else if (role == ROLE_LAT || role == ROLE_LON) begin
                        if (cif_ff < {5'd0, ndeg}) begin
                           deg_in = 10'(deg_ff * 10'd10 + {6'd0, digit_val(c)});
                        end else if (c == ".") begin
                           dseen_in = 1'b1;
                        end else if (is_digit(c) && mdig_ff < MDW'(MAX_MINUTE_DIGITS)) begin
                           min_in = MIN_W'(min_ff * MIN_W'(10) + MIN_W'(digit_val(c)));
                           mdig_in = mdig_ff + MDW'(1);
                           if (dseen_ff) ddig_in = ddig_ff + MDW'(1);
                        end
                     end else if (role == ROLE_LATHEM || role == ROLE_LONHEM) begin
                        if (cif_ff == 7'd0) begin
                           if (role == ROLE_LATHEM) latpos_in = (c == "N" || c == "E");
                           else lonpos_in = (c == "N" || c == "E");
                        end
                     end else if (role == ROLE_TIME) begin
                        if (cif_ff < 7'd6) begin
                           sod_in = sod_ff + 20'(time_weight(cif_ff[2:0]) * digit_val(c));
                        end else if (c == ".") begin
                           dseen_in = 1'b1;
                        end else if (dseen_ff && is_digit(c) && fdig_ff < 2'd3) begin
                           frac_in = 10'(frac_ff * 10'd10 + {6'd0, digit_val(c)});
                           fdig_in = fdig_ff + 2'd1;
                        end
                     end else if (role == ROLE_STATUS) begin
                        if (cif_ff == 7'd0) stat_in = (c == "A");
                     end else if (role == ROLE_DATE) begin
                        if (cif_ff < 7'd6) date_in[cif_ff[2:0]] = digit_val(c);
                     end
                     if (cif_ff != 7'd127) cif_in = cif_ff + 7'd1;
                  end else begin
                     // comma or sentence end closes the current field
                     if (tok.tok_class == TOK_COMMA) len_in = len_ff + LW'(1);
                     pend_end_in = (tok.tok_class == TOK_END);
                     if (fidx_ff == 5'd0) begin
                        talker_in = decode_talker({hdr_ff[0], hdr_ff[1]});
                        kind_in = decode_kind({hdr_ff[2], hdr_ff[3], hdr_ff[4]});
                     end
                     if (role == ROLE_LAT || role == ROLE_LON) begin
                        num_in = NUM_W'(min_ff * E7);
                        degs_in = 34'(deg_ff * E7);
                        scale_in = minute_scale(4'(ddig_ff));
                        rem_in = '0;
                        cnt_in = 6'd0;
                        state_in = S_DIV;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
               end
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            trial = {rem_ff[SCALE_W-1:0], num_ff[NUM_W-1]};
            if (trial >= {1'b0, scale_ff}) begin
               rem_in = trial - {1'b0, scale_ff};
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NUM_W - 1)) state_in = S_ADD;
         end
         S_ADD: begin
            vsum = 55'(degs_ff) + 55'(num_ff);
            vlim = (role == ROLE_LAT) ? LAT_MAX : LON_MAX;
            if (vsum > vlim) vsum = vlim;
            if (role == ROLE_LAT) lat_in = vsum[31:0];
            else lon_in = vsum[31:0];
            state_in = S_FIN;
         end
         S_FIN: begin
            if (role == ROLE_TIME) begin
               case (fdig_ff)
                  2'd0: frac_in = 10'd0;
                  2'd1: frac_in = 10'(frac_ff * 10'd100);
                  2'd2: frac_in = 10'(frac_ff * 10'd10);
                  default: frac_in = frac_ff;
               endcase
               fdig_in = 2'd3;
            end
            clear_field = 1'b1;
            if (pend_end_ff) begin
               state_in = S_DAYS;
            end else begin
               if (fidx_ff != 5'd31) fidx_in = fidx_ff + 5'd1;
               state_in = S_READY;
            end
         end
         S_DAYS: begin
            day   = 7'(date_ff[0] * 4'd10) + {3'd0, date_ff[1]};
            month = 7'(date_ff[2] * 4'd10) + {3'd0, date_ff[3]};
            yy    = 7'(date_ff[4] * 4'd10) + {3'd0, date_ff[5]};
            if (month < 7'd1) mon_c = 4'd1;
            else if (month > 7'd12) mon_c = 4'd12;
            else mon_c = month[3:0];
            days_in = EPOCH_DAYS + 17'(yy * 9'd365) + 17'((yy + 7'd3) >> 2)
                      + {8'd0, days_before_month(mon_c)}
                      + {16'd0, (yy[1:0] == 2'd0) && (mon_c > 4'd2)}
                      + {10'd0, day} - 17'd1;
            state_in = S_SECS;
         end
         S_SECS: begin
            secs = 34'(days_ff * SEC_PER_DAY) + {14'd0, sod_ff};
            unix_in = (secs > UNIX_MAX) ? UNIX_MAX[31:0] : secs[31:0];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_talker_in = talker_ff;
               o_kind_in = kind_ff;
               o_loc_in = loc;
               o_lat_in = loc ? (latpos_ff ? lat_ff[30:0] : lat_neg[30:0]) : 31'd0;
               o_lon_in = loc ? (lonpos_ff ? lon_ff : lon_neg) : 32'd0;
               o_tv_in = rmc && stat_ff;
               o_unix_in = rmc ? unix_ff : 32'd0;
               o_frac_in = rmc ? frac_ff : 10'd0;
               clear_all = 1'b1;
               state_in = S_READY;
            end
         end
         default: state_in = S_READY;
      endcase

      if (clear_field || clear_all) begin
         cif_in = '0; deg_in = '0; min_in = '0; mdig_in = '0;
         dseen_in = 1'b0; ddig_in = '0;
      end
      if (clear_all) begin
         // a dollar starts a new sentence, anything else goes idle
         phase_in = (state_ff == S_READY) && (tok.tok_class == TOK_DOLLAR);
         len_in = phase_in ? LW'(1) : LW'(0);
         fidx_in = '0; hlen_in = '0;
         for (int i = 0; i < 5; i++) hdr_in[i] = 8'd0;
         for (int i = 0; i < 6; i++) date_in[i] = 4'd0;
         lat_in = '0; lon_in = '0; latpos_in = 1'b0; lonpos_in = 1'b0;
         sod_in = '0; frac_in = '0; fdig_in = '0; stat_in = 1'b0;
         talker_in = TALK_NONE; kind_in = KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fidx_ff <= fidx_in;     cif_ff <= cif_in;       hdr_ff <= hdr_in;
      hlen_ff <= hlen_in;     len_ff <= len_in;       deg_ff <= deg_in;
      min_ff <= min_in;       mdig_ff <= mdig_in;     ddig_ff <= ddig_in;
      dseen_ff <= dseen_in;   lat_ff <= lat_in;       lon_ff <= lon_in;
      latpos_ff <= latpos_in; lonpos_ff <= lonpos_in; sod_ff <= sod_in;
      frac_ff <= frac_in;     fdig_ff <= fdig_in;     date_ff <= date_in;
      stat_ff <= stat_in;     talker_ff <= talker_in; kind_ff <= kind_in;
      pend_end_ff <= pend_end_in;
      num_ff <= num_in;       rem_ff <= rem_in;       scale_ff <= scale_in;
      degs_ff <= degs_in;     cnt_ff <= cnt_in;       days_ff <= days_in;
      unix_ff <= unix_in;
      o_talker_ff <= o_talker_in; o_kind_ff <= o_kind_in; o_loc_ff <= o_loc_in;
      o_tv_ff <= o_tv_in;     o_lat_ff <= o_lat_in;   o_lon_ff <= o_lon_in;
      o_unix_ff <= o_unix_in; o_frac_ff <= o_frac_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_talker         = o_talker_ff;
   assign rsp_sentence_kind  = o_kind_ff;
   assign rsp_location_valid = o_loc_ff;
   assign rsp_latitude_e7    = o_lat_ff;
   assign rsp_longitude_e7   = o_lon_ff;
   assign rsp_time_valid     = o_tv_ff;
   assign rsp_unix_seconds   = o_unix_ff;
   assign rsp_fraction_ms    = o_frac_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/nmea_gga_rmc_sentence_parser.sv =====
`default_nettype none
// back end: a plain character is taken in the ready state; a comma passes on through the
// field close state, and one closing a latitude or longitude field first runs the 54-step divider
// throughput: one word per cycle into a 4-word queue while the queue is not full; a sentence
// end then runs the days, seconds and emit states, and the result sits in an output register
// reset: synchronous, active high; clears the queue, parser phase and result valid
// ----------------------------------------------------------------------------
// nmea_gga_rmc_sentence_parser
// nmea 0183 parser giving talker, kind, position and utc time per sentence
// ----------------------------------------------------------------------------
module nmea_gga_rmc_sentence_parser #(
   parameter int MAX_SENTENCE_CHARS = 128,
   parameter int MAX_MINUTE_DIGITS  = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_text_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [2:0]         rsp_talker,
   output logic [2:0]         rsp_sentence_kind,
   output logic               rsp_location_valid,
   output logic signed [30:0] rsp_latitude_e7,
   output logic signed [31:0] rsp_longitude_e7,
   output logic               rsp_time_valid,
   output logic [31:0]        rsp_unix_seconds,
   output logic [9:0]         rsp_fraction_ms
);
   import nmea_pkg::*;

   // word queue between the byte classifier and the field parser
   logic      tok_valid;
   logic      tok_pop;
   token_type tok;

   // front: classify each byte as dollar, end, comma or plain character
   nmea_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .tok_valid     (tok_valid),
      .tok           (tok),
      .tok_pop       (tok_pop)
   );

   // back: field state, coordinate divider, date math and result register
   nmea_back #(
      .MAX_SENTENCE_CHARS (MAX_SENTENCE_CHARS),
      .MAX_MINUTE_DIGITS  (MAX_MINUTE_DIGITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .tok_valid          (tok_valid),
      .tok                (tok),
      .tok_pop            (tok_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_talker         (rsp_talker),
      .rsp_sentence_kind  (rsp_sentence_kind),
      .rsp_location_valid (rsp_location_valid),
      .rsp_latitude_e7    (rsp_latitude_e7),
      .rsp_longitude_e7   (rsp_longitude_e7),
      .rsp_time_valid     (rsp_time_valid),
      .rsp_unix_seconds   (rsp_unix_seconds),
      .rsp_fraction_ms    (rsp_fraction_ms)
   );

endmodule
`default_nettype wire
